@@ src/mcfb_pkg.sv @@
// Types, codes and frame constants shared by the motion command frame builder.
package mcfb_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 4;

  typedef logic [CMD_W-1:0]         cmd_code_t;
  typedef logic signed [VAL_W-1:0]  cmd_val_t;
  typedef logic [BYTE_W-1:0]        frame_byte_t;
  typedef logic [POS_W-1:0]         byte_pos_t;

  // Command codes.
  localparam cmd_code_t CMD_STOP     = 3'd0;
  localparam cmd_code_t CMD_SPEED    = 3'd1;
  localparam cmd_code_t CMD_DISTANCE = 3'd2;
  localparam cmd_code_t CMD_ANGLE    = 3'd3;

  // Frame bytes.
  localparam frame_byte_t START_BYTE  = 8'hA5;
  localparam frame_byte_t END_BYTE    = 8'h5A;
  localparam frame_byte_t ZERO_BYTE   = 8'h00;
  localparam frame_byte_t OP_SPEED    = 8'h70;
  localparam frame_byte_t OP_DISTANCE = 8'h72;
  localparam frame_byte_t OP_ANGLE    = 8'h73;
  localparam frame_byte_t LEN_SPEED   = 8'h08;
  localparam frame_byte_t LEN_TURN    = 8'h09;
  localparam frame_byte_t DIR_ONE     = 8'h01;
  localparam frame_byte_t DIR_TWO     = 8'h02;

  // Index of the final byte for each frame length.
  localparam byte_pos_t LAST_POS_SPEED = 4'd10;
  localparam byte_pos_t LAST_POS_TURN  = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_ERROR
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input item into the held registers
    logic emit_byte;  // load the current frame byte into the output register
    logic emit_err;   // load the error result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmd_bad;    // the offered command code is not a known type
    logic out_free;   // the output register can take a result this cycle
    logic last_pos;   // the current byte is the final one of the frame
  } dp_status_t;

endpackage

@@ src/mcfb_if.sv @@
// Valid/ready channel interfaces for command items and frame byte items.
interface mcfb_in_if import mcfb_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_code_t command;
  cmd_val_t  first_value;
  cmd_val_t  second_value;

  modport source(output valid, output command, output first_value, output second_value,
                 input ready);
  modport sink(input valid, input command, input first_value, input second_value,
               output ready);
endinterface

interface mcfb_out_if import mcfb_pkg::*; ();
  logic        valid;
  logic        ready;
  frame_byte_t frame_byte;
  logic        last_byte;
  logic        error;

  modport source(output valid, output frame_byte, output last_byte, output error,
                 input ready);
  modport sink(input valid, input frame_byte, input last_byte, input error,
               output ready);
endinterface

@@ src/mcfb_ctrl.sv @@
// Controller state machine that sequences capture and byte emission.
module mcfb_ctrl import mcfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.cmd_bad) begin
            state_nxt = ST_ERROR;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        if (status.out_free) begin
          cmd.emit_byte = 1'b1;
          if (status.last_pos) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (status.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/mcfb_dp.sv @@
// Datapath: held command, byte position, running checksum and output register.
module mcfb_dp import mcfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  cmd_code_t   in_command,
  input  cmd_val_t    in_first_value,
  input  cmd_val_t    in_second_value,
  output logic        out_valid,
  input  logic        out_ready,
  output frame_byte_t out_frame_byte,
  output logic        out_last_byte,
  output logic        out_error
);

  cmd_code_t   held_type_r;
  cmd_val_t    held_first_r;
  cmd_val_t    held_second_r;
  byte_pos_t   pos_r, pos_nxt;
  frame_byte_t xor_r, xor_nxt;
  logic        out_valid_r, out_valid_nxt;
  frame_byte_t out_byte_r;
  logic        out_last_r;
  logic        out_err_r;

  logic        is_speed;
  logic        positive;
  cmd_val_t    f_val;
  cmd_val_t    s_val;
  logic [VAL_W-1:0] mag;
  frame_byte_t dir_byte;
  frame_byte_t op_byte;
  frame_byte_t cur_byte;
  byte_pos_t   last_pos;

  assign is_speed = (held_type_r == CMD_STOP) || (held_type_r == CMD_SPEED);
  assign positive = (held_first_r != '0) && !held_first_r[VAL_W-1];
  assign f_val    = (held_type_r == CMD_STOP) ? '0 : held_first_r;
  assign s_val    = (held_type_r == CMD_STOP) ? '0 : held_second_r;
  assign mag      = held_first_r[VAL_W-1] ? VAL_W'(-held_first_r) : held_first_r;
  assign last_pos = is_speed ? LAST_POS_SPEED : LAST_POS_TURN;

  always_comb begin
    if (held_type_r == CMD_DISTANCE) begin
      op_byte  = OP_DISTANCE;
      dir_byte = positive ? DIR_ONE : DIR_TWO;
    end else begin
      op_byte  = OP_ANGLE;
      dir_byte = positive ? DIR_TWO : DIR_ONE;
    end
  end

  // Frame byte at the current position.
  always_comb begin
    case (pos_r)
      4'd0:    cur_byte = START_BYTE;
      4'd1:    cur_byte = ZERO_BYTE;
      4'd2:    cur_byte = is_speed ? LEN_SPEED : LEN_TURN;
      4'd3:    cur_byte = ZERO_BYTE;
      4'd4:    cur_byte = is_speed ? OP_SPEED : op_byte;
      4'd5:    cur_byte = is_speed ? f_val[15:8] : mag[15:8];
      4'd6:    cur_byte = is_speed ? f_val[7:0] : mag[7:0];
      4'd7:    cur_byte = is_speed ? s_val[15:8] : dir_byte;
      4'd8:    cur_byte = is_speed ? s_val[7:0] : held_second_r[15:8];
      4'd9:    cur_byte = is_speed ? xor_r : held_second_r[7:0];
      4'd10:   cur_byte = is_speed ? END_BYTE : xor_r;
      default: cur_byte = END_BYTE;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    if (cmd.capture) begin
      pos_nxt = '0;
      xor_nxt = '0;
    end else if (cmd.emit_byte) begin
      pos_nxt = pos_r + 1'b1;
      // Bytes after the checksum also fold in; the next capture clears them.
      if (pos_r != '0) begin
        xor_nxt = xor_r ^ cur_byte;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_byte || cmd.emit_err) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
      held_type_r <= CMD_STOP;
    end else begin
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.capture) begin
        held_type_r <= in_command;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held_first_r  <= in_first_value;
      held_second_r <= in_second_value;
    end
    if (cmd.emit_byte) begin
      out_byte_r <= cur_byte;
      out_last_r <= (pos_r == last_pos);
      out_err_r  <= 1'b0;
    end else if (cmd.emit_err) begin
      out_byte_r <= ZERO_BYTE;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign status.cmd_bad  = !(in_command inside {CMD_STOP, CMD_SPEED, CMD_DISTANCE,
                                                CMD_ANGLE});
  assign status.out_free = !out_valid_r || out_ready;
  assign status.last_pos = (pos_r == last_pos);

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;
  assign out_error      = out_err_r;

endmodule

@@ src/motion_command_frame_builder_unit.sv @@
// Top level of the motion command frame builder.
//
// The in_cmd channel takes one motion command item: a command type and two
// signed 16-bit values. For each valid command the block sends the serial frame
// on the out_res channel, one byte item at a time, with last_byte set on the
// final byte. Stop and speed frames have 11 bytes; distance and angle have 12.
// An unknown command type yields a single item with error and last_byte set.
// in_cmd.ready is high only while the controller is idle. After a command is
// accepted the controller enters its frame state and the byte sequencer loads
// each byte into the output register, one byte per cycle while the receiver
// takes them. The next command is accepted while the final byte still waits
// in the output register. When the receiver holds out_res.ready low the
// sequencer waits and the waiting item stays unchanged. Synchronous reset
// returns the controller to idle and empties the output register.
module motion_command_frame_builder_unit import mcfb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  mcfb_in_if.sink    in_cmd,
  mcfb_out_if.source out_res
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller decides when to capture a command and when to emit a byte.
  mcfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_cmd.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // The datapath builds each frame byte from the held command and position.
  mcfb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .in_command      (in_cmd.command),
    .in_first_value  (in_cmd.first_value),
    .in_second_value (in_cmd.second_value),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .out_frame_byte  (out_res.frame_byte),
    .out_last_byte   (out_res.last_byte),
    .out_error       (out_res.error)
  );

endmodule
